// ----- rtl/cchms_pkg.sv -----
package cchms_pkg;

   localparam int MaxObjectsDefault = 4095;
   localparam int ValueWidthDefault = 16;
   localparam int SlotDepth = 4096;
   localparam int AddrWidth = 12;

   localparam logic [7:0] FreeMark = 8'hFF;
   localparam logic [7:0] MarkBit = 8'h80;

   localparam logic [2:0] ReqAlloc = 3'd0;
   localparam logic [2:0] ReqFree = 3'd1;
   localparam logic [2:0] ReqMark = 3'd2;
   localparam logic [2:0] ReqSweep = 3'd3;
   localparam logic [2:0] ReqRead = 3'd4;
   localparam logic [2:0] ReqCar = 3'd5;
   localparam logic [2:0] ReqCdr = 3'd6;
   localparam logic [2:0] ReqType = 3'd7;

   localparam logic [1:0] StOk = 2'd0;
   localparam logic [1:0] StFull = 2'd1;
   localparam logic [1:0] StRange = 2'd2;
   localparam logic [1:0] StFree = 2'd3;

   localparam logic CsrHeapSize = 1'b0;
   localparam logic CsrNilValue = 1'b1;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [11:0] index;
      logic [6:0]  obj_type;
      logic [15:0] car_in;
      logic [15:0] cdr_in;
   } req_type_type;

   typedef struct packed {
      logic [11:0] handle;
      logic [1:0]  status;
      logic [6:0]  type_out;
      logic        marked;
      logic [15:0] car_out;
      logic [15:0] cdr_out;
      logic [11:0] freed_count;
      logic [11:0] used_count;
      logic [11:0] free_count;
      logic [15:0] sweep_total;
   } rsp_type_type;

   // memory access command from the sequencer: one read and one write address
   typedef struct packed {
      logic                 type_we;
      logic                 car_we;
      logic                 cdr_we;
      logic [AddrWidth-1:0] addr;
      logic [AddrWidth-1:0] raddr;
      logic [7:0]           type_wd;
   } mem_cmd_type;

   function automatic logic [6:0] clamp_type(input logic [6:0] t);
      return (t == 7'h7F) ? 7'h7E : t;
   endfunction

endpackage

// ----- rtl/cchms_store.sv -----
module cchms_store
   import cchms_pkg::*;
#(
   parameter int VALUE_WIDTH = ValueWidthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mem_cmd_type            cmd,
   input  logic [VALUE_WIDTH-1:0] car_wd,
   input  logic [VALUE_WIDTH-1:0] cdr_wd,
   output logic                   clearing,
   output logic [7:0]             type_rd,
   output logic [VALUE_WIDTH-1:0] car_rd,
   output logic [VALUE_WIDTH-1:0] cdr_rd
);

   logic [7:0]             type_mem [SlotDepth];
   logic [VALUE_WIDTH-1:0] car_mem [SlotDepth];
   logic [VALUE_WIDTH-1:0] cdr_mem [SlotDepth];
   logic                   clear_ff;
   logic [AddrWidth-1:0]   clear_addr_ff;

   assign clearing = clear_ff;

   // after reset, walk every slot once and mark it free
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         if (clear_addr_ff == AddrWidth'(SlotDepth - 1)) clear_ff <= 1'b0;
         clear_addr_ff <= clear_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         type_mem[clear_addr_ff] <= FreeMark;
      end else if (cmd.type_we) begin
         type_mem[cmd.addr] <= cmd.type_wd;
      end
      if (cmd.car_we) car_mem[cmd.addr] <= car_wd;
      if (cmd.cdr_we) cdr_mem[cmd.addr] <= cdr_wd;
      type_rd <= type_mem[cmd.raddr];
      car_rd <= car_mem[cmd.raddr];
      cdr_rd <= cdr_mem[cmd.raddr];
   end

endmodule

// ----- rtl/cons_cell_heap_mark_sweep_unit.sv -----
// Request flow to the rsp_valid strobe: read, write, free, mark and set type pass through the
// probe, check and finish states; a bad handle goes from probe to finish. Alloc checks one slot
// per cycle from the rover, up to size slots, size being the clamped heap_size. Sweep walks
// every slot below size. One request at a time; busy is high from start until the strobe.
// Reset (synchronous): counters and rover zero, heap_size 4095, nil 0; a clearing pass then
// frees all 4096 slots with busy high. The receiver cannot stall.
module cons_cell_heap_mark_sweep_unit
   import cchms_pkg::*;
#(
   parameter int MAX_OBJECTS = MaxObjectsDefault,
   parameter int VALUE_WIDTH = ValueWidthDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type_type req_data,
   output logic         rsp_valid,
   output rsp_type_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [15:0]  csr_data
);

   typedef enum logic [2:0] {
      IDLE, PROBE, CHECK, SCAN, SWEEP, DONE
   } state_type;

   state_type            state_ff;
   req_type_type         req_ff;
   logic [11:0]          heap_size_ff;
   logic [15:0]          nil_ff;
   logic [11:0]          rover_ff, used_ff, freed_ff, start_ff, pos_ff, rpos_ff;
   logic [15:0]          sweeps_ff;
   logic                 first_ff, rvalid_ff;
   rsp_type_type         rsp_ff;
   logic                 rsp_valid_ff;

   mem_cmd_type            cmd;
   logic [VALUE_WIDTH-1:0] car_wd, cdr_wd, nil_w, car_w, cdr_w;
   logic [7:0]             type_rd;
   logic [VALUE_WIDTH-1:0] car_rd, cdr_rd;
   logic                   clearing;

   logic [11:0] size;
   logic [11:0] pos_nx;
   logic [11:0] slot;

   // accept register writes only while no request is in flight
   assign csr_ready = ~busy;
   assign busy = (state_ff != IDLE) | clearing;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // clamp heap size to 1..MAX_OBJECTS
   always_comb begin
      size = heap_size_ff;
      if (size == '0) size = 12'd1;
      if (32'(size) > MAX_OBJECTS) size = 12'(MAX_OBJECTS);
   end

   assign nil_w = VALUE_WIDTH'(nil_ff);
   assign car_w = VALUE_WIDTH'(req_ff.car_in);
   assign cdr_w = VALUE_WIDTH'(req_ff.cdr_in);
   assign pos_nx = (pos_ff + 12'd1 == size) ? 12'd0 : pos_ff + 12'd1;
   assign slot = req_ff.index - 12'd1;

   cchms_store #(.VALUE_WIDTH(VALUE_WIDTH)) u_store (
      .clock(clock), .reset(reset), .cmd(cmd), .car_wd(car_wd), .cdr_wd(cdr_wd),
      .clearing(clearing), .type_rd(type_rd), .car_rd(car_rd), .cdr_rd(cdr_rd)
   );

   // drive the read address and write back the slot read last cycle
   always_comb begin
      cmd = '0;
      car_wd = nil_w;
      cdr_wd = nil_w;
      cmd.addr = pos_ff;
      cmd.raddr = pos_ff;
      unique case (state_ff)
         CHECK: begin
            cmd.addr = slot;
            cmd.raddr = slot;
            if (type_rd != FreeMark) begin
               case (req_ff.req_type)
                  ReqFree: begin
                     cmd.type_we = 1'b1; cmd.car_we = 1'b1; cmd.cdr_we = 1'b1;
                     cmd.type_wd = FreeMark;
                  end
                  ReqMark: begin
                     cmd.type_we = 1'b1; cmd.type_wd = type_rd | MarkBit;
                  end
                  ReqCar: begin
                     cmd.car_we = 1'b1; car_wd = car_w;
                  end
                  ReqCdr: begin
                     cmd.cdr_we = 1'b1; cdr_wd = cdr_w;
                  end
                  ReqType: begin
                     cmd.type_we = 1'b1; cmd.type_wd = {1'b0, clamp_type(req_ff.obj_type)};
                  end
                  default: ;
               endcase
            end
         end
         SCAN: begin
            if (rvalid_ff && type_rd == FreeMark) begin
               cmd.addr = rpos_ff;
               cmd.type_we = 1'b1; cmd.car_we = 1'b1; cmd.cdr_we = 1'b1;
               cmd.type_wd = {1'b0, clamp_type(req_ff.obj_type)};
               car_wd = car_w; cdr_wd = cdr_w;
            end
         end
         SWEEP: begin
            // write back behind the read pointer; the next slot is read meanwhile
            if (rvalid_ff && type_rd != FreeMark) begin
               cmd.addr = rpos_ff;
               cmd.type_we = 1'b1;
               if (type_rd[7]) begin
                  cmd.type_wd = {1'b0, type_rd[6:0]};
               end else begin
                  cmd.type_wd = FreeMark; cmd.car_we = 1'b1; cmd.cdr_we = 1'b1;
               end
            end
         end
         default: begin
            cmd.addr = slot;
            cmd.raddr = slot;
         end
      endcase
   end

   logic [11:0] used_dec;
   assign used_dec = (used_ff >= freed_ff) ? used_ff - freed_ff : 12'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         heap_size_ff <= 12'd4095;
         nil_ff <= '0;
         rover_ff <= '0;
         used_ff <= '0;
         sweeps_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            if (csr_index == CsrHeapSize) heap_size_ff <= csr_data[11:0];
            else nil_ff <= csr_data;
         end
         unique case (state_ff)
            IDLE: if (start && !clearing) begin
               req_ff <= req_data;
               rsp_ff <= '0;
               freed_ff <= '0;
               first_ff <= 1'b1;
               rvalid_ff <= 1'b0;
               state_ff <= PROBE;
            end
            PROBE: begin
               // hold address on the handle while its slot is read
               if (req_ff.req_type == ReqAlloc) begin
                  pos_ff <= (rover_ff < size) ? rover_ff : 12'd0;
                  start_ff <= (rover_ff < size) ? rover_ff : 12'd0;
                  state_ff <= SCAN;
               end else if (req_ff.req_type == ReqSweep) begin
                  pos_ff <= '0;
                  state_ff <= SWEEP;
               end else if (req_ff.index == '0 || req_ff.index > size) begin
                  rsp_ff.status <= StRange;
                  state_ff <= DONE;
               end else begin
                  state_ff <= CHECK;
               end
            end
            CHECK: begin
               if (type_rd == FreeMark) begin
                  rsp_ff.status <= StFree;
                  if (req_ff.req_type == ReqRead) begin
                     rsp_ff.type_out <= 7'h7F;
                     rsp_ff.car_out <= 16'(nil_w);
                     rsp_ff.cdr_out <= 16'(nil_w);
                  end
               end else if (req_ff.req_type == ReqRead) begin
                  rsp_ff.type_out <= type_rd[6:0];
                  rsp_ff.marked <= type_rd[7];
                  rsp_ff.car_out <= 16'(car_rd);
                  rsp_ff.cdr_out <= 16'(cdr_rd);
               end else if (req_ff.req_type == ReqFree && used_ff != '0) begin
                  used_ff <= used_ff - 12'd1;
               end
               state_ff <= DONE;
            end
            SCAN: begin
               // one slot read per cycle; check the slot read last cycle
               if (rvalid_ff && type_rd == FreeMark) begin
                  rover_ff <= (rpos_ff + 12'd1 == size) ? 12'd0 : rpos_ff + 12'd1;
                  if (used_ff != 12'd4095) used_ff <= used_ff + 12'd1;
                  rsp_ff.handle <= rpos_ff + 12'd1;
                  rvalid_ff <= 1'b0;
                  state_ff <= DONE;
               end else if (rvalid_ff && !first_ff && rpos_ff == start_ff) begin
                  rsp_ff.status <= StFull;
                  rvalid_ff <= 1'b0;
                  state_ff <= DONE;
               end else begin
                  if (rvalid_ff) first_ff <= 1'b0;
                  rpos_ff <= pos_ff;
                  rvalid_ff <= 1'b1;
                  pos_ff <= pos_nx;
               end
            end
            SWEEP: begin
               if (rvalid_ff && type_rd != FreeMark && !type_rd[7])
                  freed_ff <= freed_ff + 12'd1;
               if (rvalid_ff && rpos_ff + 12'd1 == size) begin
                  rvalid_ff <= 1'b0;
                  state_ff <= DONE;
               end else begin
                  rpos_ff <= pos_ff;
                  rvalid_ff <= (pos_ff < size);
                  pos_ff <= pos_ff + 12'd1;
               end
            end
            DONE: begin
               logic [11:0] u;
               u = used_ff;
               if (req_ff.req_type == ReqSweep) begin
                  u = used_dec;
                  used_ff <= used_dec;
                  sweeps_ff <= sweeps_ff + 16'd1;
                  rsp_ff.sweep_total <= sweeps_ff + 16'd1;
                  rsp_ff.freed_count <= freed_ff;
               end else begin
                  rsp_ff.sweep_total <= sweeps_ff;
               end
               rsp_ff.used_count <= u;
               rsp_ff.free_count <= (size > u) ? size - u : 12'd0;
               rsp_valid_ff <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

// ----- tb/cons_cell_heap_mark_sweep_unit_tb.sv -----
module cons_cell_heap_mark_sweep_unit_tb;
   import cchms_pkg::*;

   // heap occupancy model: slot types, words, rover and counters
   class heap_scoreboard;
      logic [7:0]  slot_type [SlotDepth];
      logic [15:0] slot_car [SlotDepth];
      logic [15:0] slot_cdr [SlotDepth];
      int unsigned rover, used_total, sweeps_done, heap_size;
      logic [15:0] nil_word;
      rsp_type_type pending_rsp[$];
      int errors;

      function new();
         foreach (slot_type[i]) begin
            slot_type[i] = FreeMark;
            slot_car[i] = '0;
            slot_cdr[i] = '0;
         end
         rover = 0; used_total = 0; sweeps_done = 0;
         heap_size = 4095; nil_word = '0; errors = 0;
      endfunction

      function int unsigned live_size();
         int unsigned s;
         s = heap_size & 12'hFFF;
         if (s == 0) s = 1;
         if (s > 4095) s = 4095;
         return s;
      endfunction

      function logic [7:0] fold_type(logic [6:0] t);
         return (t == 7'h7F) ? 8'h7E : {1'b0, t};
      endfunction

      function void write_reg(logic idx, logic [15:0] val);
         if (idx == CsrHeapSize) heap_size = val & 16'hFFF;
         else nil_word = val;
      endfunction

      // note one accepted request word and predict its response
      function void note_request(req_type_type rq);
         rsp_type_type r;
         int unsigned size, start, pos, s, freed;
         bit found, is_free;
         r = '0;
         size = live_size();
         freed = 0;
         if (rq.req_type == ReqAlloc) begin
            start = (rover < size) ? rover : 0;
            pos = start;
            found = 0;
            do begin
               if (slot_type[pos] == FreeMark) begin
                  found = 1;
                  break;
               end
               pos = (pos + 1) % size;
            end while (pos != start);
            if (found) begin
               slot_type[pos] = fold_type(rq.obj_type);
               slot_car[pos] = rq.car_in;
               slot_cdr[pos] = rq.cdr_in;
               rover = (pos + 1) % size;
               if (used_total < 4095) used_total++;
               r.handle = 12'(pos + 1);
            end else r.status = StFull;
         end else if (rq.req_type == ReqSweep) begin
            for (int i = 0; i < size; i++) begin
               if (slot_type[i] == FreeMark) continue;
               if ((slot_type[i] & MarkBit) == 0) begin
                  slot_type[i] = FreeMark;
                  slot_car[i] = nil_word;
                  slot_cdr[i] = nil_word;
                  freed++;
               end else slot_type[i] = slot_type[i] & 8'h7F;
            end
            used_total = (used_total >= freed) ? used_total - freed : 0;
            sweeps_done = (sweeps_done + 1) & 16'hFFFF;
            r.freed_count = 12'(freed);
         end else if (rq.index == 0 || rq.index > size) begin
            r.status = StRange;
         end else begin
            s = rq.index - 1;
            is_free = (slot_type[s] == FreeMark);
            if (rq.req_type == ReqRead) begin
               if (is_free) begin
                  r.status = StFree;
                  r.type_out = 7'h7F;
                  r.car_out = nil_word;
                  r.cdr_out = nil_word;
               end else begin
                  r.type_out = slot_type[s][6:0];
                  r.marked = slot_type[s][7];
                  r.car_out = slot_car[s];
                  r.cdr_out = slot_cdr[s];
               end
            end else if (is_free) r.status = StFree;
            else case (rq.req_type)
               ReqFree: begin
                  slot_type[s] = FreeMark;
                  slot_car[s] = nil_word;
                  slot_cdr[s] = nil_word;
                  if (used_total > 0) used_total--;
               end
               ReqMark: slot_type[s] = slot_type[s] | MarkBit;
               ReqCar: slot_car[s] = rq.car_in;
               ReqCdr: slot_cdr[s] = rq.cdr_in;
               default: slot_type[s] = fold_type(rq.obj_type);
            endcase
         end
         r.used_count = 12'(used_total);
         r.free_count = 12'((size > used_total) ? size - used_total : 0);
         r.sweep_total = 16'(sweeps_done);
         pending_rsp.push_back(r);
      endfunction

      function void check_response(rsp_type_type got);
         rsp_type_type e;
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected response %p", $time, got);
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         if (got.handle !== e.handle)
            $display("%0t handle exp %0d got %0d", $time, e.handle, got.handle);
         if (got.status !== e.status)
            $display("%0t status exp %0d got %0d", $time, e.status, got.status);
         if (got.type_out !== e.type_out)
            $display("%0t type_out exp %0d got %0d", $time, e.type_out, got.type_out);
         if (got.marked !== e.marked)
            $display("%0t marked exp %0d got %0d", $time, e.marked, got.marked);
         if (got.car_out !== e.car_out)
            $display("%0t car_out exp %h got %h", $time, e.car_out, got.car_out);
         if (got.cdr_out !== e.cdr_out)
            $display("%0t cdr_out exp %h got %h", $time, e.cdr_out, got.cdr_out);
         if (got.freed_count !== e.freed_count)
            $display("%0t freed exp %0d got %0d", $time, e.freed_count, got.freed_count);
         if (got.used_count !== e.used_count)
            $display("%0t used exp %0d got %0d", $time, e.used_count, got.used_count);
         if (got.free_count !== e.free_count)
            $display("%0t free exp %0d got %0d", $time, e.free_count, got.free_count);
         if (got.sweep_total !== e.sweep_total)
            $display("%0t sweeps exp %0d got %0d", $time, e.sweep_total, got.sweep_total);
         if (got !== e) errors++;
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_type_type req_data = '0;
   logic         rsp_valid;
   rsp_type_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = 1'b0;
   logic [15:0]  csr_data = '0;

   heap_scoreboard heap_sb = new();

   cons_cell_heap_mark_sweep_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // check each response word at the edge that ends its strobe cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid) heap_sb.check_response(rsp_data);
   end

   // hold start until the edge where busy is low, then drop it
   task automatic issue(req_type_type rq);
      int gap;
      gap = $urandom_range(0, 9);
      repeat (gap) @(posedge clock);
      start <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy !== 1'b0);
      heap_sb.note_request(rq);
      start <= 1'b0;
      @(posedge clock);
   endtask

   // wait for all responses, let the block settle, then write one register
   task automatic write_csr(logic idx, logic [15:0] val);
      while (heap_sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      heap_sb.write_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type_type make_req(logic [2:0] op, logic [11:0] idx);
      req_type_type rq;
      rq.req_type = op;
      rq.index = idx;
      rq.obj_type = 7'($urandom_range(0, 126));
      rq.car_in = 16'($urandom);
      rq.cdr_in = 16'($urandom);
      return rq;
   endfunction

   // pick a handle: mostly live range, sometimes zero or past the end
   function automatic logic [11:0] pick_handle(int unsigned size);
      int unsigned k;
      k = $urandom_range(0, 19);
      if (k == 0) return 12'd0;
      if (k == 1) return 12'($urandom);
      if (k == 2) return 12'(size);
      return 12'($urandom_range(1, size));
   endfunction

   initial begin
      req_type_type rq;
      int unsigned size, w;
      logic [2:0] op;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: small heap, fill to full, every op, bad handles, clamp of type
      write_csr(CsrHeapSize, 16'd4);
      write_csr(CsrNilValue, 16'hFFFF);
      rq = make_req(ReqRead, 12'd1); issue(rq);
      rq = make_req(ReqMark, 12'd1); issue(rq);
      for (int i = 0; i < 5; i++) begin
         rq = make_req(ReqAlloc, 12'd0);
         rq.obj_type = (i == 0) ? 7'h7F : (i == 1 ? 7'h00 : 7'd126);
         rq.car_in = (i == 0) ? 16'hFFFF : 16'h0000;
         rq.cdr_in = (i == 0) ? 16'h0000 : 16'hFFFF;
         issue(rq);
      end
      rq = make_req(ReqRead, 12'd0); issue(rq);
      rq = make_req(ReqRead, 12'd5); issue(rq);
      rq = make_req(ReqRead, 12'hFFF); issue(rq);
      rq = make_req(ReqMark, 12'd1); issue(rq);
      rq = make_req(ReqRead, 12'd1); issue(rq);
      rq = make_req(ReqCar, 12'd2); issue(rq);
      rq = make_req(ReqCdr, 12'd2); issue(rq);
      rq = make_req(ReqType, 12'd1); rq.obj_type = 7'h7F; issue(rq);
      rq = make_req(ReqMark, 12'd3); issue(rq);
      rq = make_req(ReqFree, 12'd4); issue(rq);
      rq = make_req(ReqFree, 12'd4); issue(rq);
      rq = make_req(ReqRead, 12'd4); issue(rq);
      rq = make_req(ReqSweep, 12'd0); issue(rq);
      rq = make_req(ReqRead, 12'd3); issue(rq);
      rq = make_req(ReqRead, 12'd2); issue(rq);
      // shrink the heap to two slots, then heap_size of zero acting as one
      write_csr(CsrHeapSize, 16'd2);
      rq = make_req(ReqAlloc, 12'd0); issue(rq);
      write_csr(CsrHeapSize, 16'd0);
      rq = make_req(ReqAlloc, 12'd0); issue(rq);
      rq = make_req(ReqSweep, 12'd0); issue(rq);

      // random phases; mostly small heaps, a few full-size ones
      for (int ph = 0; ph < 16; ph++) begin
         case (ph % 8)
            0: w = 16'hFFFF;
            1: w = 16'd4095;
            2: w = 16'd1;
            default: w = $urandom_range(1, 40);
         endcase
         write_csr(CsrHeapSize, 16'(w));
         write_csr(CsrNilValue, (ph % 3 == 0) ? 16'h0000 : 16'($urandom));
         size = heap_sb.live_size();
         for (int n = 0; n < 95; n++) begin
            w = $urandom_range(0, 99);
            if (w < 30) op = ReqAlloc;
            else if (w < 45) op = ReqMark;
            else if (w < 60) op = ReqRead;
            else if (w < 68) op = ReqFree;
            else if (w < 76) op = ReqCar;
            else if (w < 84) op = ReqCdr;
            else if (w < 92) op = ReqType;
            else op = ReqSweep;
            // large heaps: keep sweeps rare, they walk every slot
            if (size > 100 && op == ReqSweep && n % 40 != 0) op = ReqRead;
            rq = make_req(op, pick_handle(size));
            if ($urandom_range(0, 15) == 0) rq.obj_type = 7'h7F;
            issue(rq);
         end
      end

      while (heap_sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (heap_sb.errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #100000000;
      $display("FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/cchms_pkg.sv
rtl/cchms_store.sv
rtl/cons_cell_heap_mark_sweep_unit.sv
tb/cons_cell_heap_mark_sweep_unit_tb.sv
